// ===== hw/rtl/j16u8_pkg.sv =====
// shared types, constants and helpers of the utf-16 to json utf-8 encoder
`timescale 1ns / 1ps

package j16u8_pkg;

    // byte slots per queued item: quote, six-byte escape, quote
    localparam int MAX_BYTES = 8;
    localparam int IDX_W     = 3;

    // input transfer payload
    typedef struct packed {
        logic [15:0] code_unit;
        logic        unit_present;
        logic        first_of_string;
        logic        last_of_string;
    } t_in_item;

    // output transfer payload
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_byte;
    } t_out_item;

    // one classified item waiting for the back end
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [IDX_W-1:0]          last_idx;
    } t_entry;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    // ascii codes used in escapes
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_LOW_T  = 8'h74;
    localparam logic [7:0] C_LOW_N  = 8'h6E;
    localparam logic [7:0] C_LOW_R  = 8'h72;
    localparam logic [7:0] C_LOW_U  = 8'h75;
    localparam logic [7:0] C_ZERO   = 8'h30;

    // utf-16 high surrogate bounds and utf-8 one- and two-byte limits
    localparam logic [15:0] C_HIGH_FIRST = 16'hD800;
    localparam logic [15:0] C_HIGH_LAST  = 16'hDBFF;
    localparam logic [15:0] C_ASCII_MAX  = 16'h007F;
    localparam logic [15:0] C_TWO_MAX    = 16'h07FF;

    // lowercase hex digit
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'b0000, v};
        end else begin
            r = 8'h57 + {4'b0000, v};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/j16u8_front.sv =====
// front end: accepts code units, tracks surrogates, builds the byte list
`timescale 1ns / 1ps

module j16u8_front
    import j16u8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    input  t_q_status i_q_status,
    output logic      o_push,
    output t_entry    o_entry
);

    logic        r_pending;
    logic        n_pending;
    logic [15:0] r_held;
    logic [15:0] n_held;

    logic                 accept;
    logic                 pend_eff;
    logic                 is_high;
    logic [15:0]          x;
    logic [31:0]          cp;
    logic [5:0][7:0]      ub;
    logic [2:0]           ulen;
    logic [1:0]           base;
    logic [3:0]           total;
    logic [MAX_BYTES-1:0][7:0] bytes;

    assign o_ready  = !i_q_status.full;
    assign accept   = i_valid && o_ready;
    assign x        = i_data.code_unit;
    assign pend_eff = r_pending && !i_data.first_of_string;
    assign is_high  = (x >= C_HIGH_FIRST) && (x <= C_HIGH_LAST);

    // code point of a surrogate pair, modulo 2^32
    assign cp = ((32'(r_held) - 32'h0000_D800) << 10)
              + (32'(x) - 32'h0000_DC00) + 32'h0001_0000;

    // bytes of the code unit alone
    always_comb begin
        ub   = '0;
        ulen = 3'd0;
        if (i_data.unit_present) begin
            if (pend_eff) begin
                ub[0] = 8'((cp >> 18) | 32'h0000_00F0);
                ub[1] = 8'(((cp >> 12) & 32'h3F) | 32'h80);
                ub[2] = 8'(((cp >> 6) & 32'h3F) | 32'h80);
                ub[3] = 8'((cp & 32'h3F) | 32'h80);
                ulen  = 3'd4;
            end else if (x <= C_ASCII_MAX) begin
                if (x[7:0] == C_QUOTE || x[7:0] == C_BSLASH) begin
                    ub[0] = C_BSLASH;
                    ub[1] = x[7:0];
                    ulen  = 3'd2;
                end else if (x[7:0] == 8'd9) begin
                    ub[0] = C_BSLASH;
                    ub[1] = C_LOW_T;
                    ulen  = 3'd2;
                end else if (x[7:0] == 8'd10) begin
                    ub[0] = C_BSLASH;
                    ub[1] = C_LOW_N;
                    ulen  = 3'd2;
                end else if (x[7:0] == 8'd13) begin
                    ub[0] = C_BSLASH;
                    ub[1] = C_LOW_R;
                    ulen  = 3'd2;
                end else if (x[7:0] < 8'd32) begin
                    ub[0] = C_BSLASH;
                    ub[1] = C_LOW_U;
                    ub[2] = C_ZERO;
                    ub[3] = C_ZERO;
                    ub[4] = hex_digit(x[7:4]);
                    ub[5] = hex_digit(x[3:0]);
                    ulen  = 3'd6;
                end else begin
                    ub[0] = x[7:0];
                    ulen  = 3'd1;
                end
            end else if (x <= C_TWO_MAX) begin
                ub[0] = {2'b11, x[11:6]};
                ub[1] = {2'b10, x[5:0]};
                ulen  = 3'd2;
            end else if (!is_high) begin
                ub[0] = {4'hE, x[15:12]};
                ub[1] = {2'b10, x[11:6]};
                ub[2] = {2'b10, x[5:0]};
                ulen  = 3'd3;
            end
        end
    end

    // place quotes and unit bytes into the entry
    always_comb begin
        bytes = '0;
        base  = {1'b0, i_data.first_of_string};
        if (i_data.first_of_string) begin
            bytes[0] = C_QUOTE;
        end
        for (int j = 0; j < 6; j++) begin
            if (3'(j) < ulen) begin
                bytes[3'(j) + 3'(base)] = ub[j];
            end
        end
        if (i_data.last_of_string) begin
            bytes[3'(base) + ulen] = C_QUOTE;
        end
        total = 4'(base) + 4'(ulen) + 4'(i_data.last_of_string);
    end

    assign o_entry.bytes    = bytes;
    assign o_entry.last_idx = 3'(total - 4'd1);
    assign o_push           = accept && (total != 4'd0);

    // surrogate tracking
    always_comb begin
        n_pending = r_pending;
        n_held    = r_held;
        if (accept) begin
            n_pending = pend_eff;
            if (i_data.unit_present) begin
                if (pend_eff) begin
                    n_pending = 1'b0;
                end else if (is_high) begin
                    n_pending = 1'b1;
                    n_held    = x;
                end
            end
            if (i_data.last_of_string) begin
                n_pending = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 1'b0;
        end else begin
            r_pending <= n_pending;
        end
        r_held <= n_held;
    end

endmodule

// ===== hw/rtl/j16u8_fifo.sv =====
// short queue of classified items between front and back end
`timescale 1ns / 1ps

module j16u8_fifo
    import j16u8_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_entry    i_entry,
    input  logic      i_pop,
    output t_entry    o_head,
    output t_q_status o_status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_entry            r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  n_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [PTR_W-1:0]  n_rd;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    assign o_head          = r_mem[r_rd];
    assign o_status.full   = (r_count == FULL_CNT);
    assign o_status.empty  = (r_count == '0);

    // pointer and count update
    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

`ifndef SYNTHESIS
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_status.full)
        else $error("push into full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("queue count out of range");
`endif

endmodule

// ===== hw/rtl/j16u8_back.sv =====
// back end: sends the queued bytes one per cycle while the output is ready, through an output register
`timescale 1ns / 1ps

module j16u8_back
    import j16u8_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_entry    i_head,
    input  t_q_status i_q_status,
    output logic      o_pop,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic             r_valid;
    logic             n_valid;
    logic [7:0]       r_byte;
    logic             r_last;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;

    logic load;
    logic at_end;

    // take the next byte when the output register is free or draining
    assign load   = !i_q_status.empty && (!r_valid || i_ready);
    assign at_end = (r_idx == i_head.last_idx);
    assign o_pop  = load && at_end;

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (load) begin
            n_valid = 1'b1;
            n_idx   = at_end ? '0 : r_idx + 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_last <= at_end;
        end
    end

    assign o_valid          = r_valid;
    assign o_data.out_byte  = r_byte;
    assign o_data.last_byte = r_last;

`ifndef SYNTHESIS
    a_mid_entry_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> !i_q_status.empty)
        else $error("entry left the queue while partly sent");
    a_idx_in_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx != '0) |-> (r_idx <= i_head.last_idx))
        else $error("byte index past end of entry");
`endif

endmodule

// ===== hw/rtl/json_string_utf16_to_utf8_encoder_unit.sv =====
// top level of the utf-16 to json utf-8 string encoder
//
//  channel  direction  handshake           payload
//  input    in         i_valid / o_ready   i_data  (t_in_item)
//  output   out        o_valid / i_ready   o_data  (t_out_item)
//
// an input transfer is accepted whenever the queue has room
// output runs at one byte per cycle while i_ready is high; an item has up to
// eight bytes, and an item with no bytes is not queued
// the single output byte register sets that rate
// the first byte passes through the queue and then the output byte register
// reset drops a pending surrogate, empties the queue, clears output valid
// front and back stall independently, decoupled by the item queue
`timescale 1ns / 1ps

module json_string_utf16_to_utf8_encoder_unit
    import j16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_data
);

    logic      push;
    logic      pop;
    t_entry    push_entry;
    t_entry    head;
    t_q_status q_status;

    // classify and build byte lists
    j16u8_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .i_q_status (q_status),
        .o_push     (push),
        .o_entry    (push_entry)
    );

    // item queue
    j16u8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_head   (head),
        .o_status (q_status)
    );

    // serialize bytes
    j16u8_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head),
        .i_q_status (q_status),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data)
    );

endmodule
